### hw/rtl/utv_pkg.sv
// Shared types, constants and lookup functions for the UTC timestamp validator.
// No dependencies.
package utv_pkg;

	localparam int unsigned TS_LEN   = 20;
	localparam int unsigned QDEPTH   = 2;

	localparam logic [4:0] POS_LAST = 5'd19;
	localparam logic [4:0] POS_SAT  = 5'd21;

	localparam logic [2:0] FLD_SEP    = 3'd0;
	localparam logic [2:0] FLD_YEAR   = 3'd1;
	localparam logic [2:0] FLD_MONTH  = 3'd2;
	localparam logic [2:0] FLD_DAY    = 3'd3;
	localparam logic [2:0] FLD_HOUR   = 3'd4;
	localparam logic [2:0] FLD_MINUTE = 3'd5;
	localparam logic [2:0] FLD_SECOND = 3'd6;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_Z     = 8'h5a;

	localparam logic [6:0] MONTH_MAX  = 7'd12;
	localparam logic [6:0] HOUR_MAX   = 7'd23;
	localparam logic [6:0] MINUTE_MAX = 7'd59;
	localparam logic [6:0] SECOND_MAX = 7'd60;

	// one finished timestamp handed from front to back
	typedef struct packed {
		logic        fmt_ok;
		logic        leap;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} ts_rec_t;

	function automatic logic [2:0] field_code(input logic [4:0] pos);
		logic [2:0] f;
		unique case (pos)
			5'd0, 5'd1, 5'd2, 5'd3: f = FLD_YEAR;
			5'd5, 5'd6:             f = FLD_MONTH;
			5'd8, 5'd9:             f = FLD_DAY;
			5'd11, 5'd12:           f = FLD_HOUR;
			5'd14, 5'd15:           f = FLD_MINUTE;
			5'd17, 5'd18:           f = FLD_SECOND;
			default:                f = FLD_SEP;
		endcase
		return f;
	endfunction

	function automatic logic [7:0] sep_char(input logic [4:0] pos);
		logic [7:0] c;
		unique case (pos)
			5'd4, 5'd7:   c = CH_DASH;
			5'd10:        c = CH_T;
			5'd13, 5'd16: c = CH_COLON;
			default:      c = CH_Z;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] push7(input logic [6:0] acc, input logic [3:0] d);
		logic [10:0] t;
		t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {7'd0, d};
		return t[6:0];
	endfunction

	function automatic logic [13:0] push14(input logic [13:0] acc, input logic [3:0] d);
		logic [17:0] t;
		t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {14'd0, d};
		return t[13:0];
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
			4'd2:                                      n = leap ? 5'd29 : 5'd28;
			default:                                   n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

### hw/rtl/utv_front.sv
// Front end: accepts characters, checks layout, accumulates decimal fields.
// Depends on utv_pkg.
module utv_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        in_char,
	input  logic              in_last,
	input  logic              q_full,
	output logic              in_ready,
	output logic              push,
	output utv_pkg::ts_rec_t  push_rec
);

	logic [4:0]  pos_q;
	logic        layout_q;
	logic [13:0] year_q;
	logic [6:0]  yhi_q, ylo_q;
	logic [6:0]  month_q, day_q, hour_q, minute_q, second_q;

	logic        accept, in_range, is_dig, upd, layout_n;
	logic [2:0]  fld;
	logic [3:0]  dig;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && in_last;

	always_comb begin
		in_range = pos_q < utv_pkg::TS_LEN[4:0];
		fld      = utv_pkg::field_code(pos_q);
		is_dig   = (in_char >= utv_pkg::CH_ZERO) && (in_char <= utv_pkg::CH_NINE);
		dig      = in_char[3:0];
		upd      = in_range && (fld != utv_pkg::FLD_SEP) && is_dig;
		layout_n = layout_q;
		if (!in_range) begin
			layout_n = 1'b0;
		end else if (fld == utv_pkg::FLD_SEP) begin
			if (in_char != utv_pkg::sep_char(pos_q))
				layout_n = 1'b0;
		end else if (!is_dig) begin
			layout_n = 1'b0;
		end
	end

	always_comb begin
		push_rec.fmt_ok = layout_n && (pos_q == utv_pkg::POS_LAST);
		// leap: last two digits divisible by 4, and century years need first two divisible by 4
		push_rec.leap   = (ylo_q[1:0] == 2'b00) && ((ylo_q != 7'd0) || (yhi_q[1:0] == 2'b00));
		push_rec.year   = year_q;
		push_rec.month  = month_q;
		push_rec.day    = day_q;
		push_rec.hour   = hour_q;
		push_rec.minute = minute_q;
		push_rec.second = second_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			layout_q <= 1'b1;
			year_q   <= '0;
			yhi_q    <= '0;
			ylo_q    <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				pos_q    <= '0;
				layout_q <= 1'b1;
				year_q   <= '0;
				yhi_q    <= '0;
				ylo_q    <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
			end else begin
				if (pos_q < utv_pkg::POS_SAT)
					pos_q <= pos_q + 5'd1;
				layout_q <= layout_n;
				if (upd) begin
					unique case (fld)
						utv_pkg::FLD_YEAR: begin
							year_q <= utv_pkg::push14(year_q, dig);
							if (!pos_q[1])
								yhi_q <= utv_pkg::push7(yhi_q, dig);
							else
								ylo_q <= utv_pkg::push7(ylo_q, dig);
						end
						utv_pkg::FLD_MONTH:  month_q  <= utv_pkg::push7(month_q, dig);
						utv_pkg::FLD_DAY:    day_q    <= utv_pkg::push7(day_q, dig);
						utv_pkg::FLD_HOUR:   hour_q   <= utv_pkg::push7(hour_q, dig);
						utv_pkg::FLD_MINUTE: minute_q <= utv_pkg::push7(minute_q, dig);
						default:             second_q <= utv_pkg::push7(second_q, dig);
					endcase
				end
			end
		end
	end

endmodule

### hw/rtl/utv_queue.sv
// Two-entry request queue between front and back.
// Depends on utv_pkg.
module utv_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  utv_pkg::ts_rec_t  push_rec,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output utv_pkg::ts_rec_t  head_rec
);

	localparam int unsigned PW = $clog2(utv_pkg::QDEPTH);
	localparam int unsigned CW = $clog2(utv_pkg::QDEPTH + 1);

	utv_pkg::ts_rec_t entry_q [utv_pkg::QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(utv_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign head_rec  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(utv_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(utv_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### hw/rtl/utv_back.sv
// Back end: range and calendar checks, result output register.
// Depends on utv_pkg.
module utv_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_not_empty,
	input  utv_pkg::ts_rec_t  q_rec,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [39:0]       out_data,
	output logic              out_ok
);

	logic        out_valid_q, ok_q, ok;
	logic [39:0] data_q;
	logic [4:0]  maxd;

	assign pop       = q_not_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = data_q;
	assign out_ok    = ok_q;

	always_comb begin
		maxd = utv_pkg::month_days(q_rec.month[3:0], q_rec.leap);
		ok   = q_rec.fmt_ok
			&& (q_rec.month != 7'd0) && (q_rec.month <= utv_pkg::MONTH_MAX)
			&& (q_rec.hour <= utv_pkg::HOUR_MAX)
			&& (q_rec.minute <= utv_pkg::MINUTE_MAX)
			&& (q_rec.second <= utv_pkg::SECOND_MAX)
			&& (q_rec.day != 7'd0) && (q_rec.day <= {2'b00, maxd});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ok_q <= ok;
			if (ok)
				data_q <= {q_rec.second[5:0], q_rec.minute[5:0], q_rec.hour[4:0],
					q_rec.day[4:0], q_rec.month[3:0], q_rec.year};
			else
				data_q <= '0;
		end
	end

endmodule

### hw/rtl/utc_timestamp_validator_top.sv
// UTC timestamp validator, top level. Depends on utv_pkg, utv_front, utv_queue, utv_back.
// Throughput: one character per cycle; s_tready drops only while the queue holds two requests.
// The last character's request is written into a queue entry when accepted; the back end
// pops it and registers the result and m_tvalid once its output register is free.
// Reset: arst_n asynchronous active low; clears position, accumulators, queue pointers
// and the output valid, and sets the layout flag.
module utc_timestamp_validator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // is_final
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [13:0] year, [17:14] month, [22:18] day,
	                               // [27:23] hour, [33:28] minute, [39:34] second
	output logic        m_tuser    // [0] valid_res
);

	logic             push, pop, q_full, q_not_empty;
	utv_pkg::ts_rec_t push_rec, head_rec;

	utv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_char  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.in_ready (s_tready),
		.push     (push),
		.push_rec (push_rec)
	);

	utv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_rec  (head_rec)
	);

	utv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_rec       (head_rec),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.out_ok      (m_tuser)
	);

endmodule
